// ===== sv/llp_pkg.sv =====
package llp_pkg;

   localparam int NumSymbols = 64;
   localparam int MaxRules = 256;
   localparam int MaxRhs = 8;
   localparam int StackDepth = 64;
   localparam int MaxSteps = 64;

   localparam int SymW = $clog2(NumSymbols);
   localparam int RuleW = $clog2(MaxRules);
   localparam int RhsW = $clog2(MaxRhs);
   localparam int SpW = $clog2(StackDepth + 1);
   localparam int StepW = $clog2(MaxSteps);

   localparam logic [2:0] ACT_TOKEN = 3'd0;
   localparam logic [2:0] ACT_BEGIN = 3'd1;
   localparam logic [2:0] ACT_TABLE = 3'd2;
   localparam logic [2:0] ACT_RSYM  = 3'd3;
   localparam logic [2:0] ACT_RLEN  = 3'd4;

   localparam logic [2:0] EV_EXPAND = 3'd0;
   localparam logic [2:0] EV_MATCH  = 3'd1;
   localparam logic [2:0] EV_EPS    = 3'd2;
   localparam logic [2:0] EV_NORULE = 3'd3;
   localparam logic [2:0] EV_BADTOK = 3'd4;
   localparam logic [2:0] EV_EMPTY  = 3'd5;
   localparam logic [2:0] EV_OVFL   = 3'd6;
   localparam logic [2:0] EV_LIMIT  = 3'd7;

   localparam logic CSR_NUM_TERM = 1'b0;
   localparam logic CSR_START = 1'b1;

   typedef struct packed {
      logic [2:0] action;
      logic [5:0] token;
      logic [5:0] table_row;
      logic [5:0] table_col;
      logic [7:0] table_entry;
      logic [7:0] rule_number;
      logic [2:0] rhs_position;
      logic [5:0] rhs_symbol;
      logic [3:0] rhs_length;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] rule_id;
      logic [5:0] lookahead;
      logic [5:0] stack_top;
      logic       last;
      logic       parse_done;
      logic       parse_ok;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_TOP, ST_TBL, ST_DECIDE, ST_LEN, ST_PUSH, ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request, do writes / begin
      logic rd_top;      // read stack top
      logic rd_tbl;      // read table entry for top and token
      logic rd_len;      // check stack room for the rule body, set push count
      logic decide;      // evaluate step, build event
      logic push;        // push one body symbol
      logic emit;        // present event
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_token;
      logic step_end;    // decided event is last
      logic expand;      // decided event is a rule expansion
      logic push_done;
      logic out_busy;
   } sts_type;

endpackage

// ===== sv/ll1_predictive_parser_core.sv =====
// LL(1) predictive parser. A load or begin request gives no response. A token
// is accepted, then each event runs through stack read, table read, decide
// (which also reads the rule length), overflow check and emit, with registered
// stack, table and rule memory reads, plus any wait while the response register
// is stalled; an expansion adds a push step, which with a non-empty body first
// fetches and then pushes one body symbol at a time. A token yields up to 64 events.
// csr_index 0 is num_terminals, 1 is start_symbol.
module ll1_predictive_parser_core import llp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [0:0] csr_index,
   input  logic [6:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   llp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .sts, .cmd
   );

   llp_datapath u_dp (
      .clock, .reset, .req_data, .csr_write, .csr_index, .csr_data,
      .cmd, .sts, .rsp_valid, .rsp_stall, .rsp_data
   );

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed under stall");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !cmd.emit)
      else $error("emit while output full");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.parse_done |-> rsp_data.last)
      else $error("done without last");

endmodule

// ===== sv/llp_ctrl.sv =====
module llp_ctrl import llp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_TOP;
            end
         end
         ST_TOP: begin
            if (sts.is_token) begin
               cmd.rd_top = 1'b1;
               state_in = ST_TBL;
            end else state_in = ST_IDLE;
         end
         ST_TBL: begin
            cmd.rd_tbl = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = ST_LEN;
         end
         ST_LEN: begin
            cmd.rd_len = 1'b1;
            state_in = sts.expand ? ST_PUSH : ST_EMIT;
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            if (sts.push_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = sts.step_end ? ST_IDLE : ST_TOP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== sv/llp_datapath.sv =====
module llp_datapath import llp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       csr_write,
   input  logic [0:0] csr_index,
   input  logic [6:0] csr_data,
   input  cmd_type    cmd,
   output sts_type    sts,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   logic [SymW-1:0] stack_mem [StackDepth];
   logic [7:0]      table_mem [NumSymbols*NumSymbols];
   logic [SymW-1:0] body_mem  [MaxRules*MaxRhs];
   logic [3:0]      len_mem   [MaxRules];

   logic [6:0] num_term_ff;
   logic [5:0] start_ff;
   req_type    req_ff;
   logic [SpW-1:0] sp_ff;
   logic       flag_ff;
   logic [StepW-1:0] steps_ff;
   logic [SymW-1:0] top_ff;
   logic [7:0] entry_ff;
   logic [3:0] len_ff;
   logic [3:0] pidx_ff;
   logic [SymW-1:0] body_ff;
   logic       expand_ff, end_ff;
   rsp_type    ev_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   logic       fetch_ok_ff;

   logic [RuleW-1:0] rule_r;
   logic [3:0]  len_clip;
   logic [SpW:0] need;
   logic        tok_ok;
   logic        push_fire;
   rsp_type     ev_next;
   logic        end_next, expand_next, step_next;
   logic [SpW-1:0] sp_next;

   assign rule_r = entry_ff[RuleW-1:0];
   assign tok_ok = (req_ff.action == ACT_TOKEN);
   // body read is registered; a push fires only once body_ff matches pidx_ff
   assign push_fire = cmd.push && fetch_ok_ff && (pidx_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_term_ff <= 7'd1;
         start_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_NUM_TERM) num_term_ff <= csr_data;
         else start_ff <= csr_data[5:0];
      end
   end

   // grammar stores and their registered reads
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (req_data.action == ACT_TABLE)
            table_mem[{req_data.table_row, req_data.table_col}] <= req_data.table_entry;
         if (req_data.action == ACT_RSYM)
            body_mem[{req_data.rule_number[RuleW-1:0], req_data.rhs_position}]
               <= req_data.rhs_symbol;
         if (req_data.action == ACT_RLEN) len_mem[req_data.rule_number] <= req_data.rhs_length;
      end
      if (cmd.rd_top) top_ff <= stack_mem[SymW'(sp_ff - SpW'(1))];
      if (cmd.rd_tbl) entry_ff <= table_mem[{top_ff, req_ff.token}];
      if (cmd.decide) len_ff <= len_mem[rule_r];
      // while pushing, fetch one position ahead
      body_ff <= body_mem[{rule_r, push_fire ? pidx_ff[RhsW-1:0] - RhsW'(2)
                                             : pidx_ff[RhsW-1:0] - RhsW'(1)}];
   end

   assign len_clip = (len_ff > 4'(MaxRhs)) ? 4'(MaxRhs) : len_ff;
   assign need = {1'b0, sp_ff} - 1'b1 + (SpW+1)'(len_clip);

   always_comb begin
      ev_next.event_res = EV_EXPAND;
      ev_next.rule_id = '0;
      ev_next.lookahead = req_ff.token;
      ev_next.stack_top = (sp_ff == '0) ? '0 : top_ff;
      ev_next.last = 1'b1;
      ev_next.parse_done = 1'b0;
      ev_next.parse_ok = flag_ff;
      end_next = 1'b1;
      expand_next = 1'b0;
      step_next = 1'b0;
      sp_next = sp_ff;
      if (steps_ff == StepW'(MaxSteps - 1)) begin
         ev_next.event_res = EV_LIMIT;
         ev_next.parse_done = 1'b1;
         sp_next = '0;
      end else if (sp_ff == '0) begin
         ev_next.event_res = EV_EMPTY;
         ev_next.parse_done = 1'b1;
      end else if ({1'b0, top_ff} < num_term_ff) begin
         ev_next.event_res = (top_ff == req_ff.token) ? EV_MATCH : EV_BADTOK;
         if (top_ff != req_ff.token) ev_next.parse_ok = 1'b0;
         ev_next.parse_done = (req_ff.token == '0);
         sp_next = (req_ff.token == '0) ? '0 : sp_ff - SpW'(1);
      end else if (entry_ff == 8'd0) begin
         ev_next.event_res = EV_NORULE;
         ev_next.parse_ok = 1'b0;
         sp_next = sp_ff - SpW'(1);
      end else if (entry_ff == 8'd1) begin
         ev_next.event_res = EV_EPS;
         ev_next.last = 1'b0;
         end_next = 1'b0;
         sp_next = sp_ff - SpW'(1);
         step_next = 1'b1;
      end else begin
         // expansion: overflow check after length read
         ev_next.rule_id = entry_ff;
         ev_next.last = 1'b0;
         end_next = 1'b0;
         expand_next = 1'b1;
         step_next = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (reset) begin
         sp_ff <= '0;
         flag_ff <= 1'b1;
         steps_ff <= '0;
         expand_ff <= 1'b0;
         end_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            steps_ff <= '0;
            if (req_data.action == ACT_BEGIN) begin
               stack_mem[0] <= '0;
               stack_mem[1] <= start_ff;
               sp_ff <= SpW'(2);
               flag_ff <= 1'b1;
            end
         end
         if (cmd.decide) begin
            ev_ff <= ev_next;
            end_ff <= end_next;
            expand_ff <= expand_next;
            flag_ff <= ev_next.parse_ok;
            sp_ff <= sp_next;
            if (step_next) steps_ff <= steps_ff + 1'b1;
         end
         if (cmd.rd_len && expand_ff) begin
            if (need > (SpW+1)'(StackDepth)) begin
               ev_ff.event_res <= EV_OVFL;
               ev_ff.last <= 1'b1;
               ev_ff.parse_done <= 1'b1;
               end_ff <= 1'b1;
               expand_ff <= 1'b0;
               sp_ff <= '0;
               pidx_ff <= '0;
            end else begin
               pidx_ff <= len_clip;
               sp_ff <= sp_ff - SpW'(1);
            end
         end
         if (push_fire) begin
            stack_mem[SymW'(sp_ff)] <= body_ff;
            sp_ff <= sp_ff + SpW'(1);
            pidx_ff <= pidx_ff - 4'd1;
         end
      end
   end

   // first push cycle only fetches
   always_ff @(posedge clock) begin
      if (reset) fetch_ok_ff <= 1'b0;
      else fetch_ok_ff <= cmd.push;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      if (cmd.emit) rsp_ff <= ev_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign sts.is_token = tok_ok;
   assign sts.step_end = end_ff;
   assign sts.expand = expand_ff;
   assign sts.push_done = (pidx_ff == '0);
   assign sts.out_busy = rsp_valid_ff && rsp_stall;

endmodule

// ===== verif/tb_ll1_predictive_parser_core.sv =====
`timescale 1ns / 1ps

module tb_ll1_predictive_parser_core;
   import llp_pkg::*;

   localparam int WatchLimit = 20000;
   localparam int SettleCycles = 40;
   localparam logic [2:0] ACT_UNUSED = 3'd5;
   localparam int ReqW = $bits(req_type);
   // stack symbols and looked-up tokens stay below this, rules in LowRule..HighRule
   localparam int SmallSyms = 8;
   localparam int LowRule = 2;
   localparam int HighRule = 9;
   localparam int RandomPerPhase = 40;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_write;
   logic [0:0] csr_index;
   logic [6:0] csr_data;

   ll1_predictive_parser_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // parser state as the block should hold it
   logic [5:0] sym_stack [StackDepth];
   int         depth;
   logic [7:0] parse_tbl [NumSymbols * NumSymbols];
   logic [5:0] rule_body [MaxRules * MaxRhs];
   logic [3:0] rule_len [MaxRules];
   logic       ok_flag;
   logic [6:0] num_term;
   logic [5:0] start_sym;

   req_type pending_reqs [$];
   rsp_type expected_events [$];
   int      errors;
   int      snd_idle;
   int      rcv_idle;
   int      quiet_cycles;

   function automatic rsp_type make_event(logic [2:0] ev, logic [7:0] rid, logic [5:0] la,
                                          logic [5:0] top, logic lst, logic done);
      rsp_type e;
      e.event_res = ev;
      e.rule_id = rid;
      e.lookahead = la;
      e.stack_top = top;
      e.last = lst;
      e.parse_done = done;
      e.parse_ok = ok_flag;
      return e;
   endfunction

   task automatic parse_request(input req_type r);
      int steps;
      int len;
      int rn;
      logic [5:0] top;
      logic [7:0] ent;
      logic [5:0] tok;
      steps = 0;
      tok = r.token;
      case (r.action)
         ACT_BEGIN: begin
            sym_stack[0] = 6'd0;
            sym_stack[1] = start_sym;
            depth = 2;
            ok_flag = 1'b1;
            return;
         end
         ACT_TABLE: begin
            parse_tbl[{r.table_row, r.table_col}] = r.table_entry;
            return;
         end
         ACT_RSYM: begin
            rule_body[{r.rule_number, r.rhs_position}] = r.rhs_symbol;
            return;
         end
         ACT_RLEN: begin
            rule_len[r.rule_number] = r.rhs_length;
            return;
         end
         ACT_TOKEN: ;
         default: return;
      endcase
      while (steps < MaxSteps - 1) begin
         if (depth == 0) begin
            expected_events.push_back(make_event(EV_EMPTY, 8'd0, tok, 6'd0, 1'b1, 1'b1));
            return;
         end
         top = sym_stack[depth - 1];
         if (top < num_term) begin
            if (top != tok) ok_flag = 1'b0;
            depth--;
            if (tok == 6'd0) depth = 0;
            expected_events.push_back(make_event((top != tok) ? EV_BADTOK : EV_MATCH, 8'd0,
                                                 tok, top, 1'b1, tok == 6'd0));
            return;
         end
         ent = parse_tbl[{top, tok}];
         if (ent == 8'd0) begin
            ok_flag = 1'b0;
            depth--;
            expected_events.push_back(make_event(EV_NORULE, 8'd0, tok, top, 1'b1, 1'b0));
            return;
         end else if (ent == 8'd1) begin
            depth--;
            expected_events.push_back(make_event(EV_EPS, 8'd0, tok, top, 1'b0, 1'b0));
         end else begin
            rn = ent % MaxRules;
            len = rule_len[rn];
            if (len > MaxRhs) len = MaxRhs;
            if (depth - 1 + len > StackDepth) begin
               depth = 0;
               expected_events.push_back(make_event(EV_OVFL, ent, tok, top, 1'b1, 1'b1));
               return;
            end
            expected_events.push_back(make_event(EV_EXPAND, ent, tok, top, 1'b0, 1'b0));
            depth--;
            for (int i = len; i > 0; i--) begin
               sym_stack[depth] = rule_body[rn * MaxRhs + i - 1];
               depth++;
            end
         end
         steps++;
      end
      top = (depth != 0) ? sym_stack[depth - 1] : 6'd0;
      depth = 0;
      expected_events.push_back(make_event(EV_LIMIT, 8'd0, tok, top, 1'b1, 1'b1));
   endtask

   // request driver, response stall and model update
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) parse_request(req_data);
         if (!(req_valid && req_stall)) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < rcv_idle);
      end
   end

   // event monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected event %p", rsp_data);
         end else begin
            rsp_type want;
            want = expected_events.pop_front();
            if (rsp_data !== want) begin
               errors++;
               if (errors <= 10) $display("event mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   // watchdog on a stuck handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic queue_req(input logic [2:0] act, input logic [5:0] tok);
      req_type r;
      r = ReqW'({$urandom, $urandom});
      r.action = act;
      r.token = tok;
      pending_reqs.push_back(r);
   endtask

   task automatic queue_table(input logic [5:0] row, input logic [5:0] col,
                              input logic [7:0] ent);
      req_type r;
      r = ReqW'({$urandom, $urandom});
      r.action = ACT_TABLE;
      r.table_row = row;
      r.table_col = col;
      r.table_entry = ent;
      pending_reqs.push_back(r);
   endtask

   task automatic queue_rsym(input logic [7:0] rn, input logic [2:0] pos,
                             input logic [5:0] sym);
      req_type r;
      r = ReqW'({$urandom, $urandom});
      r.action = ACT_RSYM;
      r.rule_number = rn;
      r.rhs_position = pos;
      r.rhs_symbol = sym;
      pending_reqs.push_back(r);
   endtask

   task automatic queue_rlen(input logic [7:0] rn, input logic [3:0] len);
      req_type r;
      r = ReqW'({$urandom, $urandom});
      r.action = ACT_RLEN;
      r.rule_number = rn;
      r.rhs_length = len;
      pending_reqs.push_back(r);
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_grammar_regs(input logic [6:0] nt, input logic [5:0] ss);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_NUM_TERM;
      csr_data <= nt;
      @(posedge clock);
      csr_index <= CSR_START;
      csr_data <= {1'b0, ss};
      @(posedge clock);
      csr_write <= 1'b0;
      num_term = nt;
      start_sym = ss;
   endtask

   task automatic queue_random(input int count);
      int nt;
      int pick;
      logic [5:0] tok;
      logic [5:0] row;
      logic [5:0] col;
      logic [7:0] rn;
      nt = (num_term > SmallSyms) ? SmallSyms : num_term;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            queue_req(ACT_BEGIN, 6'($urandom));
         end else if (pick < 72) begin
            case ($urandom_range(9))
               0, 1: tok = 6'd0;
               // any token is safe once every stack symbol is a terminal
               2: tok = (num_term >= SmallSyms) ? 6'($urandom)
                                                : 6'($urandom_range(SmallSyms - 1));
               default: tok = 6'($urandom_range(nt - 1));
            endcase
            queue_req(ACT_TOKEN, tok);
         end else if (pick < 84) begin
            row = ($urandom_range(99) < 80) ? 6'($urandom_range(nt, SmallSyms - 1))
                                            : 6'($urandom);
            col = ($urandom_range(99) < 80) ? 6'($urandom_range(nt - 1)) : 6'($urandom);
            queue_table(row, col, (row < SmallSyms && col < SmallSyms)
                                  ? 8'($urandom_range(0, HighRule)) : 8'($urandom));
         end else if (pick < 93) begin
            rn = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(LowRule, HighRule));
            queue_rsym(rn, 3'($urandom), (rn <= HighRule || rn == 8'd255)
                                         ? 6'($urandom_range(SmallSyms - 1)) : 6'($urandom));
         end else if (pick < 98) begin
            queue_rlen(($urandom_range(9) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(LowRule, HighRule)),
                       ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3)));
         end else begin
            queue_req(3'($urandom_range(ACT_UNUSED, 7)), 6'($urandom));
         end
      end
   endtask

   initial begin
      errors = 0;
      depth = 0;
      ok_flag = 1'b1;
      num_term = 7'd1;
      start_sym = 6'd0;
      snd_idle = 13;
      rcv_idle = 84;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // every table and rule entry that can be looked up gets written first
      for (int i = 0; i < SmallSyms * SmallSyms; i++)
         queue_table(6'(i / SmallSyms), 6'(i % SmallSyms), 8'd0);
      for (int rr = LowRule; rr <= HighRule; rr++) begin
         for (int p = 0; p < MaxRhs; p++) queue_rsym(8'(rr), 3'(p), 6'd0);
         queue_rlen(8'(rr), 4'd0);
      end
      // S=4: on 1 -> "1 5"; on 3 -> "4" (runs to step limit); on 2 -> 8 x "4" (overflows)
      queue_table(6'd4, 6'd1, 8'd2);
      queue_rsym(8'd2, 3'd0, 6'd1);
      queue_rsym(8'd2, 3'd1, 6'd5);
      queue_rlen(8'd2, 4'd2);
      queue_table(6'd4, 6'd3, 8'd3);
      queue_rsym(8'd3, 3'd0, 6'd4);
      queue_rlen(8'd3, 4'd1);
      queue_table(6'd4, 6'd2, 8'd255);
      for (int p = 0; p < 8; p++) queue_rsym(8'd255, 3'(p), 6'd4);
      queue_rlen(8'd255, 4'd15);
      queue_table(6'd5, 6'd2, 8'd1);
      queue_table(6'd5, 6'd0, 8'd1);
      queue_table(6'd4, 6'd63, 8'd0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         snd_idle = (ph < 2) ? 13 : (ph < 4) ? 84 : 0;
         rcv_idle = (ph < 2) ? 84 : (ph < 4) ? 13 : 0;
         case (ph)
            0: set_grammar_regs(7'd4, 6'd4);
            1: set_grammar_regs(7'd64, 6'd0);
            2: set_grammar_regs(7'd1, 6'(SmallSyms - 1));
            3: set_grammar_regs(7'd4, 6'd4);
            default: set_grammar_regs(7'($urandom_range(1, 64)),
                                      6'($urandom_range(SmallSyms - 1)));
         endcase
         if (ph == 0) begin
            queue_req(ACT_TOKEN, 6'd1);       // no parse running
            queue_req(ACT_BEGIN, 6'd0);
            queue_req(ACT_TOKEN, 6'd1);       // expand then match
            queue_req(ACT_TOKEN, 6'd2);       // epsilon then bad token
            queue_req(ACT_TOKEN, 6'd2);       // empty stack
            queue_req(ACT_BEGIN, 6'd0);
            queue_req(ACT_TOKEN, 6'd0);       // no rule
            queue_req(ACT_TOKEN, 6'd0);       // end of input
            queue_req(ACT_BEGIN, 6'd0);
            queue_req(ACT_TOKEN, 6'd3);       // step limit
            queue_req(ACT_BEGIN, 6'd0);
            queue_req(ACT_TOKEN, 6'd2);       // overflow
            queue_req(ACT_BEGIN, 6'd0);
            queue_req(ACT_TOKEN, 6'd1);
            queue_req(ACT_TOKEN, 6'd1);
            queue_req(ACT_TOKEN, 6'd0);
            queue_req(ACT_BEGIN, 6'd0);
            queue_req(ACT_TOKEN, 6'd63);
            queue_req(ACT_UNUSED, 6'd1);
            queue_req(3'(ACT_UNUSED + 3'd1), 6'd1);
            queue_req(3'(ACT_UNUSED + 3'd2), 6'd1);
         end
         queue_random(RandomPerPhase);
         drain();
      end

      errors += expected_events.size();
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/llp_pkg.sv
sv/llp_ctrl.sv
sv/llp_datapath.sv
sv/ll1_predictive_parser_core.sv
verif/tb_ll1_predictive_parser_core.sv
